// ===== hw/rtl/gesp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph edge store package
// Shared widths, codes and helper functions of the edge store and its channels.
// ----------------------------------------------------------------------------
package gesp_pkg;

    // Field widths of the request and response beats.
    localparam int OPCODE_W = 2;
    localparam int ACTOR_W  = 7;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 13;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTOR_COUNT   = 1'd1;

    // Defaults and limits.
    localparam int DEF_MAX_ACTORS = 64;
    localparam logic [ACTOR_W-1:0] RESET_ACTOR_COUNT = 7'd64;
    localparam logic [TOTAL_W-1:0] TALLY_MAX = 13'h1FFF;
    localparam int CHUNK_W = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TOGGLE = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    // Shared partner kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_OTP = 2'd0,
        KIND_ISP = 2'd1,
        KIND_OSP = 2'd2,
        KIND_ITP = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SELF  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_T,
        ST_CAPT,
        ST_EVAL,
        ST_WR2,
        ST_COUNT,
        ST_DONE
    } state_t;

    // Population count of one 64-bit chunk.
    function automatic logic [6:0] pop64(input logic [CHUNK_W-1:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            n = n + 7'(x[i]);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/gesp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge store request channel
// Valid/ready channel carrying one edge operation or count request per beat.
// ----------------------------------------------------------------------------
interface gesp_req_if
    import gesp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ACTOR_W-1:0]  from_actor;
    logic [ACTOR_W-1:0]  to_actor;
    logic [KIND_W-1:0]   partner_kind;

    modport source (
        output valid, opcode, from_actor, to_actor, partner_kind,
        input  ready
    );

    modport sink (
        input  valid, opcode, from_actor, to_actor, partner_kind,
        output ready
    );
endinterface

// ===== hw/rtl/gesp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge store response channel
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface gesp_rsp_if
    import gesp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  partner_count;
    logic                edge_present;
    logic [TOTAL_W-1:0]  edge_total;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, partner_count, edge_present, edge_total, status,
        input  ready
    );

    modport sink (
        input  valid, partner_count, edge_present, edge_total, status,
        output ready
    );
endinterface

// ===== hw/rtl/graph_edge_store_shared_partners_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph edge store with shared partner counting
// Adjacency matrix and its transpose in two row RAMs, with an edge tally.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) takes one beat per operation: toggle, add or delete the edge
//   from_actor -> to_actor, or count the shared partners of the pair.
//   rsp (source) returns exactly one beat per request: partner count, edge
//   presence after the operation, edge total and status.
//   cfg_we/cfg_index/cfg_data write directed_mode (index 0) and actor_count
//   (index 1); write them only while no request is in flight.
// Timing:
//   Each request that passes its checks reads the two rows of from_actor and
//   then those of to_actor from the out-row and in-row RAMs, one row per RAM
//   per cycle. Its steps are RD_T, CAPT and EVAL; an undirected change adds
//   WR2 to write the mirror rows, and a count adds COUNT (the popcount takes
//   one 64-bit chunk per cycle). A refused request goes straight to DONE,
//   which loads the response into the output register.
// Reset:
//   After reset both RAMs are cleared one row per cycle while req.ready
//   stays low. Configuration writes are taken meanwhile.
// Stall:
//   The response sits in an output register; the next request is accepted
//   while it waits, and that request finishes once the register is free.
// ----------------------------------------------------------------------------
module graph_edge_store_shared_partners_core
    import gesp_pkg::*;
#(
    parameter int MAX_ACTORS = DEF_MAX_ACTORS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gesp_req_if.sink              req,
    gesp_rsp_if.source            rsp
);

    localparam int AW  = (MAX_ACTORS > 1) ? $clog2(MAX_ACTORS) : 1;
    localparam int CH  = (MAX_ACTORS + CHUNK_W - 1) / CHUNK_W;
    localparam int CW  = (CH > 1) ? $clog2(CH) : 1;
    localparam int VW  = CH * CHUNK_W;
    localparam int NWC = $clog2(MAX_ACTORS + 1);
    localparam int NW  = (NWC > ACTOR_W) ? NWC : ACTOR_W;

    // Configuration registers.
    logic                directed_reg;
    logic [ACTOR_W-1:0]  actor_count_reg;

    // Sequencer and request registers.
    state_t              state_reg;
    state_t              state_next;
    op_t                 op_reg;
    kind_t               kind_reg;
    status_t             status_reg;
    logic [AW-1:0]       f_reg;
    logic [AW-1:0]       t_reg;
    logic [AW-1:0]       clr_addr_reg;

    // Row copies and counting datapath.
    logic [MAX_ACTORS-1:0] out_f_reg;
    logic [MAX_ACTORS-1:0] in_f_reg;
    logic [MAX_ACTORS-1:0] out_t_reg;
    logic [MAX_ACTORS-1:0] in_t_reg;
    logic [VW-1:0]         and_vec_reg;
    logic [CW-1:0]         chunk_reg;
    logic [NW-1:0]         cnt_reg;
    logic                  present_reg;
    logic [TOTAL_W-1:0]    tally_reg;

    // Output register.
    logic                rsp_valid_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;
    logic                rsp_present_reg;
    logic [TOTAL_W-1:0]  rsp_total_reg;
    logic [STATUS_W-1:0] rsp_status_reg;

    // RAM ports.
    logic                  mem_we;
    logic [AW-1:0]         wa_out;
    logic [AW-1:0]         wa_in;
    logic [MAX_ACTORS-1:0] wd_out;
    logic [MAX_ACTORS-1:0] wd_in;
    logic [AW-1:0]         rd_addr;
    logic [MAX_ACTORS-1:0] rd_out;
    logic [MAX_ACTORS-1:0] rd_in;

    // Combinational helpers.
    logic                  req_fire;
    logic                  rsp_load;
    logic [NW-1:0]         n_eff;
    logic                  from_ok;
    logic                  to_ok;
    status_t               acc_status;
    logic                  old_bit;
    logic                  new_bit;
    logic                  change;
    logic [MAX_ACTORS-1:0] mask;
    logic [MAX_ACTORS-1:0] op_a;
    logic [MAX_ACTORS-1:0] op_b;
    logic [MAX_ACTORS-1:0] out_f_new;
    logic [MAX_ACTORS-1:0] in_t_new;
    logic [MAX_ACTORS-1:0] out_t_new;
    logic [MAX_ACTORS-1:0] in_f_new;
    logic [AW-1:0]         req_f;

    gesp_ram #(.WIDTH(MAX_ACTORS), .DEPTH(MAX_ACTORS)) u_out_rows (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wa_out),
        .wr_data (wd_out),
        .rd_addr (rd_addr),
        .rd_data (rd_out)
    );

    gesp_ram #(.WIDTH(MAX_ACTORS), .DEPTH(MAX_ACTORS)) u_in_rows (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wa_in),
        .wr_data (wd_in),
        .rd_addr (rd_addr),
        .rd_data (rd_in)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg    <= 1'b1;
            actor_count_reg <= RESET_ACTOR_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTED_MODE: directed_reg    <= cfg_data[0];
                CFG_ACTOR_COUNT:   actor_count_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Actors in use, clipped to the store size, and the range checks.
    always_comb
    begin
        if (NW'(actor_count_reg) > NW'(MAX_ACTORS))
        begin
            n_eff = NW'(MAX_ACTORS);
        end
        else
        begin
            n_eff = NW'(actor_count_reg);
        end
        from_ok = (req.from_actor != '0) && (NW'(req.from_actor) <= n_eff);
        to_ok   = (req.to_actor != '0) && (NW'(req.to_actor) <= n_eff);
        if (!from_ok || !to_ok)
        begin
            acc_status = STATUS_RANGE;
        end
        else if ((op_t'(req.opcode) != OP_COUNT) && (req.from_actor == req.to_actor))
        begin
            acc_status = STATUS_SELF;
        end
        else
        begin
            acc_status = STATUS_OK;
        end
        req_f = AW'(req.from_actor - ACTOR_W'(1));
    end

    // Partners numbered beyond the actor count are masked out.
    always_comb
    begin
        for (int k = 0; k < MAX_ACTORS; k++)
        begin
            mask[k] = NW'(k) < n_eff;
        end
    end

    // Edge test, new edge value and the modified rows.
    always_comb
    begin
        old_bit = out_f_reg[t_reg];
        case (op_reg)
            OP_ADD:    new_bit = 1'b1;
            OP_DELETE: new_bit = 1'b0;
            default:   new_bit = !old_bit;
        endcase
        change = new_bit != old_bit;

        out_f_new = out_f_reg;
        out_f_new[t_reg] = new_bit;
        in_t_new = in_t_reg;
        in_t_new[f_reg] = new_bit;
        out_t_new = out_t_reg;
        out_t_new[f_reg] = present_reg;
        in_f_new = in_f_reg;
        in_f_new[t_reg] = present_reg;
    end

    // Operand rows of the shared partner count.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (kind_reg)
            KIND_OTP:
            begin
                op_a = out_f_reg;
                op_b = in_t_reg;
            end
            KIND_ISP:
            begin
                op_a = in_f_reg;
                op_b = in_t_reg;
            end
            KIND_OSP:
            begin
                op_a = out_f_reg;
                op_b = out_t_reg;
            end
            KIND_ITP:
            begin
                op_a = in_f_reg;
                op_b = out_t_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        if (!directed_reg && (kind_reg != KIND_OSP))
        begin
            op_a = '0;
        end
    end

    assign req_fire = req.valid && req.ready;
    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // Next state and RAM control.
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        wa_out     = f_reg;
        wa_in      = t_reg;
        wd_out     = out_f_new;
        wd_in      = in_t_new;
        rd_addr    = t_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                wa_out = clr_addr_reg;
                wa_in  = clr_addr_reg;
                wd_out = '0;
                wd_in  = '0;
                if (clr_addr_reg == AW'(MAX_ACTORS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rd_addr = req_f;
                if (req_fire)
                begin
                    state_next = (acc_status == STATUS_OK) ? ST_RD_T : ST_DONE;
                end
            end
            ST_RD_T:
            begin
                rd_addr    = t_reg;
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (op_reg == OP_COUNT)
                begin
                    state_next = ST_COUNT;
                end
                else
                begin
                    mem_we = change;
                    state_next = (change && !directed_reg) ? ST_WR2 : ST_DONE;
                end
            end
            ST_WR2:
            begin
                mem_we     = 1'b1;
                wa_out     = t_reg;
                wa_in      = f_reg;
                wd_out     = out_t_new;
                wd_in      = in_f_new;
                state_next = ST_DONE;
            end
            ST_COUNT:
            begin
                if (chunk_reg == CW'(CH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register, clear sweep and edge tally.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            tally_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if ((state_reg == ST_EVAL) && (op_reg != OP_COUNT) && change)
            begin
                if (new_bit && (tally_reg != TALLY_MAX))
                begin
                    tally_reg <= tally_reg + TOTAL_W'(1);
                end
                else if (!new_bit && (tally_reg != '0))
                begin
                    tally_reg <= tally_reg - TOTAL_W'(1);
                end
            end
        end
    end

    // Request capture, row copies and the chunked popcount.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_reg      <= op_t'(req.opcode);
                    kind_reg    <= kind_t'(req.partner_kind);
                    status_reg  <= acc_status;
                    f_reg       <= req_f;
                    t_reg       <= AW'(req.to_actor - ACTOR_W'(1));
                    cnt_reg     <= '0;
                    present_reg <= 1'b0;
                end
            end
            ST_RD_T:
            begin
                out_f_reg <= rd_out;
                in_f_reg  <= rd_in;
            end
            ST_CAPT:
            begin
                out_t_reg <= rd_out;
                in_t_reg  <= rd_in;
            end
            ST_EVAL:
            begin
                if (op_reg == OP_COUNT)
                begin
                    present_reg <= old_bit;
                    and_vec_reg <= VW'(op_a & op_b & mask);
                    chunk_reg   <= '0;
                end
                else
                begin
                    present_reg <= new_bit;
                end
            end
            ST_COUNT:
            begin
                cnt_reg   <= cnt_reg + NW'(pop64(and_vec_reg[chunk_reg * CHUNK_W +: CHUNK_W]));
                chunk_reg <= chunk_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_count_reg   <= cnt_reg[COUNT_W-1:0];
            rsp_present_reg <= present_reg;
            rsp_total_reg   <= tally_reg;
            rsp_status_reg  <= status_reg;
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.partner_count = rsp_count_reg;
    assign rsp.edge_present  = rsp_present_reg;
    assign rsp.edge_total    = rsp_total_reg;
    assign rsp.status        = rsp_status_reg;

    // The tally moves only when an edge change is decided.
    a_tally_only_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EVAL) |=> (tally_reg == $past(tally_reg)))
        else $error("edge tally changed outside the evaluate step");

    // The RAMs are written only by the clear sweep and the edge write-back.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_EVAL || state_reg == ST_WR2))
        else $error("row RAM written outside clear or write-back");

    // A new response beat is always loaded from the done step.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_DONE))
        else $error("response became valid without a finished request");

    // No request is taken while the clear sweep runs.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req_fire)
        else $error("request accepted during the clear sweep");

endmodule

// ===== hw/rtl/gesp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gesp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/graph_edge_store_shared_partners_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph edge store with shared partner counting: self-checking testbench
// Drives edge changes and shared-partner count requests over the request
// channel under random back-pressure on both sides. A shadow adjacency matrix
// with its transpose and edge tally predicts every response beat. Register
// settings are changed between phases while the store is idle. A short
// directed table comes first, followed by random phases.
// ----------------------------------------------------------------------------
module graph_edge_store_shared_partners_core_tb;
    import gesp_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOT_ACTORS    = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int MAX_SHOWN     = 40;

    typedef struct packed {
        logic [COUNT_W-1:0] partner_count;
        logic               edge_present;
        logic [TOTAL_W-1:0] edge_total;
        status_t            status;
    } result_beat_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        op_t                   op;
        logic [ACTOR_W-1:0]    from_actor;
        logic [ACTOR_W-1:0]    to_actor;
        kind_t                 kind;
        bit                    pinned;
        result_beat_t          want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gesp_req_if req_ch ();
    gesp_rsp_if rsp_ch ();

    graph_edge_store_shared_partners_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the graph and of the register settings.
    logic [DEF_MAX_ACTORS-1:0] link_out [DEF_MAX_ACTORS];
    logic [DEF_MAX_ACTORS-1:0] link_in  [DEF_MAX_ACTORS];
    logic [TOTAL_W-1:0]        link_tally;
    bit                        shadow_directed;
    logic [CFG_DATA_W-1:0]     shadow_actors;

    // Results owed by the store, oldest first.
    result_beat_t due_results [$];

    // Directed stimulus table.
    plan_row_t plan [$];

    // Side information of the request beat being driven.
    bit           item_pinned;
    result_beat_t item_want;

    bit idle_on;
    int err_count;
    int n_accepted;
    int n_count_req;
    int n_refused;
    int n_checked;
    int n_writes;
    int quiet_cycles;

    initial
    begin
        for (int i = 0; i < DEF_MAX_ACTORS; i++)
        begin
            link_out[i] = '0;
            link_in[i]  = '0;
        end
        link_tally      = '0;
        shadow_directed = 1'b1;
        shadow_actors   = RESET_ACTOR_COUNT;
        err_count       = 0;
        n_accepted      = 0;
        n_count_req     = 0;
        n_refused       = 0;
        n_checked       = 0;
        n_writes        = 0;
        quiet_cycles    = 0;
    end

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_beat_t beat(int cnt, bit present, int total, status_t st);
        result_beat_t b;
        b.partner_count = COUNT_W'(cnt);
        b.edge_present  = present;
        b.edge_total    = TOTAL_W'(total);
        b.status        = st;
        return b;
    endfunction

    function automatic plan_row_t op_row(op_t op, int fa, int ta, kind_t kind,
                                         bit pinned, result_beat_t want);
        plan_row_t r;
        r.is_write   = 1'b0;
        r.reg_index  = CFG_DIRECTED_MODE;
        r.reg_value  = '0;
        r.op         = op;
        r.from_actor = ACTOR_W'(fa);
        r.to_actor   = ACTOR_W'(ta);
        r.kind       = kind;
        r.pinned     = pinned;
        r.want       = want;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
        plan_row_t r;
        r = op_row(OP_COUNT, 0, 0, KIND_OTP, 1'b0, '0);
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = CFG_DATA_W'(val);
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void queue_row(plan_row_t r);
        plan = {plan, r};
    endfunction

    // One directed edge in the matrix and its transpose.
    function automatic void set_link(int f, int t, bit v);
        link_out[f][t] = v;
        link_in[t][f]  = v;
    endfunction

    // Undirected mode tests only from->to, then writes both directions.
    function automatic void add_link(int f, int t);
        if (link_out[f][t])
            return;
        set_link(f, t, 1'b1);
        if (!shadow_directed)
            set_link(t, f, 1'b1);
        if (link_tally != TALLY_MAX)
            link_tally++;
    endfunction

    function automatic void drop_link(int f, int t);
        if (!link_out[f][t])
            return;
        set_link(f, t, 1'b0);
        if (!shadow_directed)
            set_link(t, f, 1'b0);
        if (link_tally != '0)
            link_tally--;
    endfunction

    // Applies one request to the shadow graph and returns its response.
    function automatic result_beat_t graph_step(op_t op, logic [ACTOR_W-1:0] fa,
                                                logic [ACTOR_W-1:0] ta, kind_t kind);
        result_beat_t              r;
        int                        n;
        int                        f;
        int                        t;
        logic [DEF_MAX_ACTORS-1:0] live;
        logic [DEF_MAX_ACTORS-1:0] shared;
        n    = (shadow_actors > DEF_MAX_ACTORS) ? DEF_MAX_ACTORS : int'(shadow_actors);
        live = ~({DEF_MAX_ACTORS{1'b1}} << n);
        r    = '0;
        r.status = STATUS_OK;
        f = int'(fa) - 1;
        t = int'(ta) - 1;
        if (fa < 1 || fa > n || ta < 1 || ta > n)
        begin
            r.status = STATUS_RANGE;
        end
        else if (op == OP_COUNT)
        begin
            shared = '0;
            if (kind == KIND_OSP)
                shared = link_out[f] & link_out[t];
            else if (shadow_directed)
            begin
                case (kind)
                    KIND_OTP: shared = link_out[f] & link_in[t];
                    KIND_ISP: shared = link_in[f] & link_in[t];
                    default:  shared = link_in[f] & link_out[t];
                endcase
            end
            r.partner_count = COUNT_W'($countones(shared & live));
            r.edge_present  = link_out[f][t];
        end
        else if (f == t)
        begin
            r.status = STATUS_SELF;
        end
        else
        begin
            case (op)
                OP_ADD:    add_link(f, t);
                OP_DELETE: drop_link(f, t);
                default:
                begin
                    if (link_out[f][t])
                        drop_link(f, t);
                    else
                        add_link(f, t);
                end
            endcase
            r.edge_present = link_out[f][t];
        end
        r.edge_total = link_tally;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: mirrors register writes, predicts accepted requests and
    // checks every response beat against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        result_beat_t want;
        result_beat_t got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                n_writes++;
                if (cfg_index == CFG_DIRECTED_MODE)
                    shadow_directed = cfg_data[0];
                else
                    shadow_actors = cfg_data;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.partner_count = rsp_ch.partner_count;
                got.edge_present  = rsp_ch.edge_present;
                got.edge_total    = rsp_ch.edge_total;
                got.status        = status_t'(rsp_ch.status);
                if (due_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("%0t: response beat with nothing awaited, expected none, actual %h",
                                 $time, got);
                end
                else
                begin
                    want = due_results.pop_front();
                    n_checked++;
                    check_field("partner_count", 16'(want.partner_count), 16'(got.partner_count));
                    check_field("edge_present", 16'(want.edge_present), 16'(got.edge_present));
                    check_field("edge_total", 16'(want.edge_total), 16'(got.edge_total));
                    check_field("status", 16'(want.status), 16'(got.status));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                want = graph_step(op_t'(req_ch.opcode), req_ch.from_actor, req_ch.to_actor,
                                  kind_t'(req_ch.partner_kind));
                if (item_pinned)
                    want = item_want;
                due_results = {due_results, want};
                n_accepted++;
                if (req_ch.opcode == OP_COUNT)
                    n_count_req++;
                if (want.status != STATUS_OK)
                    n_refused++;
            end
        end
    end

    // Watchdog on cycles without any beat or register write.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results still awaited",
                         $time, quiet_cycles, due_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Response back-pressure: random bursts of stall while idling is on.
    initial
    begin : rsp_pacing
        int run_left;
        rsp_ch.ready = 1'b1;
        run_left     = 0;
        forever
        begin
            @(negedge clk);
            if (!idle_on)
            begin
                rsp_ch.ready = 1'b1;
                run_left     = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if (rsp_ch.ready && $urandom_range(0, 2) == 0)
                        rsp_ch.ready = 1'b0;
                    else
                        rsp_ch.ready = 1'b1;
                    run_left = $urandom_range(1, 16);
                end
                run_left--;
            end
        end
    end

    // Register write, only once every owed result has come back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random idle gap before a request beat, taken now and then while idling is on.
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clk);
        end
    endtask

    // Drives one request beat and waits until it is taken.
    task automatic send_op(op_t op, logic [ACTOR_W-1:0] fa, logic [ACTOR_W-1:0] ta,
                           kind_t kind, bit pinned, result_beat_t want);
        @(negedge clk);
        req_ch.valid        = 1'b1;
        req_ch.opcode       = op;
        req_ch.from_actor   = fa;
        req_ch.to_actor     = ta;
        req_ch.partner_kind = kind;
        item_pinned         = pinned;
        item_want           = want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int           count_plan [RANDOM_PHASES];
        bit           mode_plan [RANDOM_PHASES];
        int           eff;
        int           hot;
        int           reps;
        int           pick;
        logic [ACTOR_W-1:0] fa;
        logic [ACTOR_W-1:0] ta;
        op_t          op;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_DIRECTED_MODE;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_TOGGLE;
        req_ch.from_actor   = '0;
        req_ch.to_actor     = '0;
        req_ch.partner_kind = KIND_OTP;
        item_pinned         = 1'b0;
        item_want           = '0;
        idle_on             = 1'b1;

        count_plan = '{64, 1, 8, 2, 127, 4, 0, 16, 3, 100, 6, 64};
        mode_plan  = '{1, 0, 1, 0, 1, 1, 0, 0, 1, 0, 1, 0};

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty store, duplicates, all kinds, refusals.
        queue_row(op_row(OP_COUNT, 1, 64, KIND_OSP, 1, beat(0, 0, 0, STATUS_OK)));
        queue_row(op_row(OP_ADD, 1, 2, KIND_OTP, 1, beat(0, 1, 1, STATUS_OK)));
        queue_row(op_row(OP_ADD, 1, 2, KIND_OTP, 1, beat(0, 1, 1, STATUS_OK)));
        queue_row(op_row(OP_TOGGLE, 2, 1, KIND_OTP, 1, beat(0, 1, 2, STATUS_OK)));
        queue_row(op_row(OP_ADD, 2, 64, KIND_OTP, 0, '0));
        queue_row(op_row(OP_ADD, 64, 1, KIND_OTP, 0, '0));
        queue_row(op_row(OP_ADD, 1, 64, KIND_OTP, 0, '0));
        queue_row(op_row(OP_COUNT, 1, 64, KIND_OTP, 0, '0));
        queue_row(op_row(OP_COUNT, 1, 2, KIND_ISP, 0, '0));
        queue_row(op_row(OP_COUNT, 2, 64, KIND_OSP, 0, '0));
        // A count on a self pair is served as usual.
        queue_row(op_row(OP_COUNT, 1, 1, KIND_ITP, 0, '0));
        queue_row(op_row(OP_TOGGLE, 5, 5, KIND_OTP, 1, beat(0, 0, 5, STATUS_SELF)));
        queue_row(op_row(OP_ADD, 0, 3, KIND_OTP, 1, beat(0, 0, 5, STATUS_RANGE)));
        queue_row(op_row(OP_DELETE, 3, 65, KIND_ISP, 1, beat(0, 0, 5, STATUS_RANGE)));
        queue_row(op_row(OP_COUNT, 127, 127, KIND_ITP, 1, beat(0, 0, 5, STATUS_RANGE)));
        queue_row(op_row(OP_DELETE, 1, 2, KIND_OTP, 1, beat(0, 0, 4, STATUS_OK)));
        queue_row(op_row(OP_DELETE, 1, 2, KIND_OTP, 1, beat(0, 0, 4, STATUS_OK)));
        queue_row(op_row(OP_TOGGLE, 1, 2, KIND_OTP, 1, beat(0, 1, 5, STATUS_OK)));
        // Undirected mode keeps the stored bits; only out-shared counts.
        queue_row(reg_row(CFG_DIRECTED_MODE, 0));
        queue_row(op_row(OP_COUNT, 1, 2, KIND_OTP, 1, beat(0, 1, 5, STATUS_OK)));
        queue_row(op_row(OP_ADD, 3, 4, KIND_OTP, 0, '0));
        queue_row(op_row(OP_DELETE, 2, 1, KIND_OTP, 0, '0));
        queue_row(op_row(OP_COUNT, 1, 3, KIND_ISP, 0, '0));
        // Partners above the actor count are ignored.
        queue_row(reg_row(CFG_ACTOR_COUNT, 2));
        queue_row(op_row(OP_COUNT, 1, 2, KIND_OSP, 0, '0));
        queue_row(op_row(OP_ADD, 1, 64, KIND_OTP, 0, '0));
        // No actor in use at all, then a count above the maximum.
        queue_row(reg_row(CFG_ACTOR_COUNT, 0));
        queue_row(op_row(OP_COUNT, 1, 1, KIND_OSP, 1, beat(0, 0, 5, STATUS_RANGE)));
        queue_row(reg_row(CFG_ACTOR_COUNT, 127));
        queue_row(reg_row(CFG_DIRECTED_MODE, 1));
        queue_row(op_row(OP_COUNT, 2, 64, KIND_OSP, 0, '0));

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
            begin
                idle_gap();
                send_op(plan[i].op, plan[i].from_actor, plan[i].to_actor, plan[i].kind,
                        plan[i].pinned, plan[i].want);
            end
        end

        // Random phases. Most pairs fall among a few hot actors so that the
        // graph gets dense enough for nonzero counts; the rest is noise.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on = (p != 3) && (p < RANDOM_PHASES - 2);
            write_reg(CFG_DIRECTED_MODE, CFG_DATA_W'(mode_plan[p]));
            write_reg(CFG_ACTOR_COUNT, CFG_DATA_W'(count_plan[p]));
            eff  = (count_plan[p] > DEF_MAX_ACTORS) ? DEF_MAX_ACTORS : count_plan[p];
            hot  = (eff > HOT_ACTORS) ? HOT_ACTORS : eff;
            reps = (eff < 2) ? 40 : 180;
            repeat (reps)
            begin
                pick = $urandom_range(0, 99);
                if (eff == 0 || pick < 8)
                begin
                    fa = ACTOR_W'($urandom_range(0, 127));
                    ta = ACTOR_W'($urandom_range(0, 127));
                end
                else if (pick < 12)
                begin
                    fa = ACTOR_W'($urandom_range(1, eff));
                    ta = fa;
                end
                else
                begin
                    fa = ($urandom_range(0, 9) < 7) ? ACTOR_W'($urandom_range(1, hot))
                                                    : ACTOR_W'($urandom_range(1, eff));
                    ta = ($urandom_range(0, 9) < 7) ? ACTOR_W'($urandom_range(1, hot))
                                                    : ACTOR_W'($urandom_range(1, eff));
                end
                op = ($urandom_range(0, 99) < 35) ? OP_COUNT : op_t'($urandom_range(0, 2));
                idle_gap();
                send_op(op, fa, ta, kind_t'($urandom_range(0, 3)), 1'b0, '0);
            end
        end

        // Drain the owed results, then watch for stray beats.
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d requests (%0d counts, %0d refused) and %0d register writes.",
                 n_accepted, n_count_req, n_refused, n_writes);
        $display("%0d response beats checked, %0d field mismatches.", n_checked, err_count);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
